// File: sv/bqtlb_pkg.sv
package bqtlb_pkg;

	// fixed field widths
	localparam int OP_W      = 2;
	localparam int LEVEL_W   = 12;
	localparam int ITEM_W    = 32;
	localparam int COUNT_W   = 17;
	localparam int STATUS_W  = 2;

	// slave tdata layout: level, item, count
	localparam int S_LEVEL_LSB = 0;
	localparam int S_ITEM_LSB  = S_LEVEL_LSB + LEVEL_W;
	localparam int S_COUNT_LSB = S_ITEM_LSB + ITEM_W;
	localparam int S_TDATA_W   = 64;

	// master tdata layout: popped_item, lowest_level, queue_empty, new_minimum
	localparam int M_POP_LSB   = 0;
	localparam int M_LOW_LSB   = M_POP_LSB + ITEM_W;
	localparam int M_EMPTY_BIT = M_LOW_LSB + LEVEL_W;
	localparam int M_NEWMIN_BIT = M_EMPTY_BIT + 1;
	localparam int M_TDATA_W   = 48;

	// two-level bitmap geometry
	localparam int ROW_W     = 64;
	localparam int ROWS      = 64;
	localparam int ROW_IDX_W = 6;

	// parameter defaults
	localparam int NUM_LEVELS_DEF  = 4096;
	localparam int STORE_DEPTH_DEF = 65536;
	localparam int ITEM_BITS_DEF   = 32;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_POP_EMPTY = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_LOAD_OVF  = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic find1;
		logic find2;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_find;
	} dp_stat_t;

	// index of the lowest set bit of a non-zero word
	function automatic logic [ROW_IDX_W-1:0] lowest_bit(input logic [ROW_W-1:0] w);
		logic [ROW_W-1:0] v;
		logic [ROW_IDX_W-1:0] n;
		v = w;
		n = '0;
		if (v[31:0] == '0) begin
			n[5] = 1'b1;
			v = v >> 32;
		end
		if (v[15:0] == '0) begin
			n[4] = 1'b1;
			v = v >> 16;
		end
		if (v[7:0] == '0) begin
			n[3] = 1'b1;
			v = v >> 8;
		end
		if (v[3:0] == '0) begin
			n[2] = 1'b1;
			v = v >> 4;
		end
		if (v[1:0] == '0) begin
			n[1] = 1'b1;
			v = v >> 2;
		end
		if (v[0] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

// File: sv/bqtlb_ctrl.sv
module bqtlb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  bqtlb_pkg::dp_stat_t   stat,
	output bqtlb_pkg::ctrl_cmd_t  cmd
);
	import bqtlb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_FIND1 = 5'b00100,
		ST_FIND2 = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// commands and next state
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_find ? ST_FIND1 : ST_DONE;
			end
			ST_FIND1: begin
				cmd.find1 = 1'b1;
				state_d   = ST_FIND2;
			end
			ST_FIND2: begin
				cmd.find2 = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

// File: sv/bqtlb_dp.sv
module bqtlb_dp #(
	parameter int NUM_LEVELS  = bqtlb_pkg::NUM_LEVELS_DEF,
	parameter int STORE_DEPTH = bqtlb_pkg::STORE_DEPTH_DEF,
	parameter int ITEM_BITS   = bqtlb_pkg::ITEM_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bqtlb_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [bqtlb_pkg::OP_W-1:0]      s_tuser,
	output logic [bqtlb_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [bqtlb_pkg::STATUS_W-1:0]  m_tuser,
	input  bqtlb_pkg::ctrl_cmd_t            cmd,
	output bqtlb_pkg::dp_stat_t             stat
);
	import bqtlb_pkg::*;

	localparam int LV_AW   = $clog2(NUM_LEVELS);
	localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int SA_W    = $clog2(STORE_DEPTH);
	localparam int STORE_W = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
	localparam int SUM_W   = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
	localparam int LVX_W   = LEVEL_W + 1;

	// memories
	logic [CNT_W-1:0]   base_mem  [NUM_LEVELS];
	logic [CNT_W-1:0]   top_mem   [NUM_LEVELS];
	logic [STORE_W-1:0] store_mem [STORE_DEPTH];
	logic [ROW_W-1:0]   row_mem   [ROWS];

	// control state
	logic [ROWS-1:0]    row_vld_q;
	logic [ROWS-1:0]    word_q;
	logic [LEVEL_W-1:0] min_q;
	logic [CNT_W-1:0]   total_q;

	// latched item
	op_t                op_q;
	logic [LEVEL_W-1:0] lev_q;
	logic [STORE_W-1:0] item_q;
	logic [COUNT_W-1:0] count_q;

	// registered read data
	logic [CNT_W-1:0]   base_rd_q;
	logic [CNT_W-1:0]   top_rd_q;
	logic [ROW_W-1:0]   row_rd_q;
	logic               row_vld_rd_q;
	logic [STORE_W-1:0] st_rd_q;

	// result registers
	logic               take_q;
	logic [ITEM_W-1:0]  popped_q;
	logic               newmin_q;
	status_t            status_q;
	logic [ROW_IDX_W-1:0] grp_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]  m_tuser_q;

	// incoming fields
	op_t                in_op;
	logic [LEVEL_W-1:0] in_lev;
	logic [ITEM_W-1:0]  in_item;
	logic [COUNT_W-1:0] in_count;
	logic [LVX_W-1:0]   in_lev_nxt;

	// read addresses
	logic [LV_AW-1:0]     base_ra;
	logic [LV_AW-1:0]     top_ra;
	logic [ROW_IDX_W-1:0] row_ra;
	logic                 row_re;

	// execute step
	logic [ROW_W-1:0]     row_cur;
	logic                 lev_ok;
	logic [LVX_W-1:0]     lev_nxt;
	logic [CNT_W-1:0]     load_start;
	logic [SUM_W-1:0]     load_sum;
	logic                 load_ok;
	logic [CNT_W-1:0]     bucket_end;
	logic                 push_ok;
	logic                 pop_ok;
	logic [CNT_W-1:0]     top_dec;
	logic                 pop_take;
	logic                 pop_clear;
	logic [ROW_IDX_W-1:0] bit_sel;
	logic [ROW_IDX_W-1:0] row_idx;
	logic [ROW_W-1:0]     bit_mask;
	logic                 row_we;
	logic [ROW_W-1:0]     row_wd;
	logic                 top_we;
	logic [LV_AW-1:0]     top_wa;
	logic [CNT_W-1:0]     top_wd;
	logic                 set_min;
	status_t              status_d;
	logic [LEVEL_W-1:0]   lowest;

	assign in_op      = op_t'(s_tuser);
	assign in_lev     = s_tdata[S_LEVEL_LSB +: LEVEL_W];
	assign in_item    = s_tdata[S_ITEM_LSB +: ITEM_W];
	assign in_count   = s_tdata[S_COUNT_LSB +: COUNT_W];
	assign in_lev_nxt = {1'b0, in_lev} + LVX_W'(1);

	// read addresses: item fields at accept, lowest group during the search
	always_comb begin
		if (in_op == OP_POP) begin
			base_ra = min_q[LV_AW-1:0];
			top_ra  = min_q[LV_AW-1:0];
		end else begin
			base_ra = in_lev_nxt[LV_AW-1:0];
			top_ra  = in_lev[LV_AW-1:0];
		end
		if (cmd.accept) begin
			row_ra = (in_op == OP_POP) ? min_q[LEVEL_W-1 -: ROW_IDX_W]
			                           : in_lev[LEVEL_W-1 -: ROW_IDX_W];
		end else begin
			row_ra = lowest_bit(word_q);
		end
		row_re = cmd.accept || cmd.find1;
	end

	// decode of the item against the read data
	always_comb begin
		row_cur    = row_vld_rd_q ? row_rd_q : '0;
		lev_ok     = {1'b0, lev_q} < LVX_W'(NUM_LEVELS);
		lev_nxt    = {1'b0, lev_q} + LVX_W'(1);
		load_start = (lev_q == '0) ? '0 : total_q;
		load_sum   = SUM_W'(load_start) + SUM_W'(count_q);
		load_ok    = (op_q == OP_LOAD) && lev_ok && (load_sum <= SUM_W'(STORE_DEPTH));
		bucket_end = (lev_nxt < LVX_W'(NUM_LEVELS)) ? base_rd_q : total_q;
		push_ok    = (op_q == OP_PUSH) && lev_ok && (top_rd_q < bucket_end)
		             && (SUM_W'(top_rd_q) < SUM_W'(STORE_DEPTH));
		pop_ok     = (op_q == OP_POP) && (word_q != '0);
		top_dec    = (top_rd_q != '0) ? top_rd_q - CNT_W'(1) : top_rd_q;
		pop_take   = pop_ok && (top_rd_q != '0) && (SUM_W'(top_dec) < SUM_W'(STORE_DEPTH));
		pop_clear  = pop_ok && (top_dec <= base_rd_q);
		bit_sel    = (op_q == OP_POP) ? min_q[ROW_IDX_W-1:0] : lev_q[ROW_IDX_W-1:0];
		row_idx    = (op_q == OP_POP) ? min_q[LEVEL_W-1 -: ROW_IDX_W]
		                              : lev_q[LEVEL_W-1 -: ROW_IDX_W];
		bit_mask   = ROW_W'(1) << bit_sel;
		row_we     = (load_ok && (lev_q != '0)) || push_ok || pop_clear;
		row_wd     = push_ok ? (row_cur | bit_mask) : (row_cur & ~bit_mask);
		top_we     = load_ok || push_ok || pop_ok;
		top_wa     = pop_ok ? min_q[LV_AW-1:0] : lev_q[LV_AW-1:0];
		if (load_ok) begin
			top_wd = load_start;
		end else if (push_ok) begin
			top_wd = top_rd_q + CNT_W'(1);
		end else begin
			top_wd = top_dec;
		end
		set_min = push_ok && ((word_q == '0) || (lev_q < min_q));
		unique case (op_q)
			OP_LOAD: status_d = load_ok ? STAT_OK : STAT_LOAD_OVF;
			OP_PUSH: status_d = push_ok ? STAT_OK : STAT_FULL;
			OP_POP:  status_d = pop_ok ? STAT_OK : STAT_POP_EMPTY;
			default: status_d = STAT_OK;
		endcase
		lowest = (word_q == '0) ? '0 : min_q;
	end

	assign stat.need_find = load_ok || pop_ok;

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_op;
			lev_q   <= in_lev;
			item_q  <= in_item[STORE_W-1:0];
			count_q <= in_count;
		end
	end

	// bucket pointer memories
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			base_rd_q <= base_mem[base_ra];
			top_rd_q  <= top_mem[top_ra];
		end
		if (cmd.exec && load_ok) begin
			base_mem[lev_q[LV_AW-1:0]] <= load_start;
		end
		if (cmd.exec && top_we) begin
			top_mem[top_wa] <= top_wd;
		end
	end

	// item store
	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			store_mem[top_rd_q[SA_W-1:0]] <= item_q;
		end
		if (cmd.exec) begin
			st_rd_q <= store_mem[top_dec[SA_W-1:0]];
		end
	end

	// level bitmap rows
	always_ff @(posedge clk) begin
		if (row_re) begin
			row_rd_q     <= row_mem[row_ra];
			row_vld_rd_q <= row_vld_q[row_ra];
		end
		if (cmd.exec && row_we) begin
			row_mem[row_idx] <= row_wd;
		end
	end

	// row valid bits, group bitmap, minimum, running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			word_q    <= '0;
			min_q     <= '0;
			total_q   <= '0;
		end else begin
			if (cmd.exec) begin
				if (load_ok) begin
					total_q <= load_sum[CNT_W-1:0];
				end
				if (load_ok && (lev_q == '0)) begin
					row_vld_q <= '0;
					word_q    <= '0;
				end else if (row_we) begin
					row_vld_q[row_idx] <= 1'b1;
					if (push_ok) begin
						word_q[row_idx] <= 1'b1;
					end else if (row_wd == '0) begin
						word_q[row_idx] <= 1'b0;
					end
				end
				if (set_min) begin
					min_q <= lev_q;
				end
			end
			if (cmd.find2) begin
				min_q <= (word_q == '0) ? '0 : {grp_q, lowest_bit(row_cur)};
			end
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			newmin_q <= set_min;
			take_q   <= pop_take;
			popped_q <= '0;
		end
		if (cmd.find1) begin
			grp_q <= lowest_bit(word_q);
			if (take_q) begin
				popped_q <= ITEM_W'(st_rd_q);
			end
		end
		if (cmd.out_load) begin
			m_tdata_q <= {{(M_TDATA_W - M_NEWMIN_BIT - 1){1'b0}}, newmin_q,
			              (word_q == '0), lowest, popped_q};
			m_tuser_q <= status_q;
		end
	end

	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

// File: sv/bucket_queue_two_level_bitmap_top.sv
// push, unused operation and rejected items pass from accept through the execute step to the result
// load and pop pass from accept through the execute step, a read-modify-write of the bucket
// and bitmap memories, then a two-step lowest-level search (group word, then row)
// a new item is accepted only after the previous result has been loaded for output, which waits on m_tready
// reset: arst_n clears the controller, the bitmaps and the running total at once; the
// bucket pointers and the item store hold nothing valid until loaded and pushed
module bucket_queue_two_level_bitmap_top #(
	parameter int NUM_LEVELS  = bqtlb_pkg::NUM_LEVELS_DEF,
	parameter int STORE_DEPTH = bqtlb_pkg::STORE_DEPTH_DEF,
	parameter int ITEM_BITS   = bqtlb_pkg::ITEM_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// level [11:0], item [43:12], count [60:44], zero [63:61]
	input  logic [bqtlb_pkg::S_TDATA_W-1:0] s_tdata,
	// operation [1:0]
	input  logic [bqtlb_pkg::OP_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// popped_item [31:0], lowest_level [43:32], queue_empty [44], new_minimum [45], zero [47:46]
	output logic [bqtlb_pkg::M_TDATA_W-1:0] m_tdata,
	// status [1:0]
	output logic [bqtlb_pkg::STATUS_W-1:0]  m_tuser
);
	import bqtlb_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer
	bqtlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// bucket memories, bitmaps and result register
	bqtlb_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.STORE_DEPTH (STORE_DEPTH),
		.ITEM_BITS   (ITEM_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

// File: sv/bqtlb_checker.sv
module bqtlb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [bqtlb_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [bqtlb_pkg::OP_W-1:0]      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bqtlb_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [bqtlb_pkg::STATUS_W-1:0]  m_tuser
);
	import bqtlb_pkg::*;

	logic                 empty;
	logic                 newmin;
	logic [LEVEL_W-1:0]   lowest;
	logic [ITEM_W-1:0]    popped;

	assign empty  = m_tdata[M_EMPTY_BIT];
	assign newmin = m_tdata[M_NEWMIN_BIT];
	assign lowest = m_tdata[M_LOW_LSB +: LEVEL_W];
	assign popped = m_tdata[M_POP_LSB +: ITEM_W];

	// a result waiting on the sink holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an empty queue reports level zero
	a_empty_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && empty |-> lowest == '0)
		else $error("empty queue with nonzero lowest level");

	// a pop from an empty queue leaves it empty and takes nothing
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_POP_EMPTY) |-> empty && (popped == '0))
		else $error("failed pop reported an item or a filled queue");

	// a new minimum only comes from a successful push, and the queue is then not empty
	a_newmin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && newmin |-> (m_tuser == STAT_OK) && !empty && (popped == '0))
		else $error("new minimum flagged on a result that is no push");

endmodule

bind bucket_queue_two_level_bitmap_top bqtlb_checker u_bqtlb_checker (.*);

// File: tb/bucket_queue_monitor.sv
`timescale 1ns / 100ps

module bucket_queue_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// level [11:0], item [43:12], count [60:44], zero [63:61]
	input  logic [bqtlb_pkg::S_TDATA_W-1:0] s_tdata,
	// operation [1:0]
	input  logic [bqtlb_pkg::OP_W-1:0]      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// popped_item [31:0], lowest_level [43:32], queue_empty [44], new_minimum [45], zero [47:46]
	input  logic [bqtlb_pkg::M_TDATA_W-1:0] m_tdata,
	// status [1:0]
	input  logic [bqtlb_pkg::STATUS_W-1:0]  m_tuser,
	output int                              fail_count,
	output int                              results_owed
);
	import bqtlb_pkg::*;

	localparam int NUM_LVL = NUM_LEVELS_DEF;
	localparam int DEPTH   = STORE_DEPTH_DEF;

	typedef struct packed {
		logic [ITEM_W-1:0]  popped_item;
		logic [LEVEL_W-1:0] lowest_level;
		logic               queue_empty;
		logic               new_minimum;
		status_t            status;
	} queue_result_t;

	// shadow of the queue state
	logic [COUNT_W-1:0] region_base [NUM_LVL];
	logic [COUNT_W-1:0] fill_ptr [NUM_LVL];
	logic [ITEM_W-1:0]  item_mem [DEPTH];
	logic [ROW_W-1:0]   row_bits [ROWS];
	logic [ROWS-1:0]    group_bits;
	logic [LEVEL_W-1:0] low_level;
	logic [COUNT_W-1:0] total_count;

	queue_result_t pending_results[$];

	initial begin
		fail_count = 0;
		results_owed = 0;
		foreach (row_bits[i])
			row_bits[i] = '0;
		group_bits = '0;
		low_level = '0;
		total_count = '0;
	end

	function automatic int first_set(logic [ROW_W-1:0] w);
		int idx;
		idx = 0;
		for (int i = ROW_W - 1; i >= 0; i--)
			if (w[i])
				idx = i;
		return idx;
	endfunction

	// two-step search: lowest group, then lowest level in that group
	function automatic void refresh_min();
		int g;
		if (group_bits == '0) begin
			low_level = '0;
		end else begin
			g = first_set(group_bits);
			low_level = LEVEL_W'(g * ROW_W + first_set(row_bits[g]));
		end
	endfunction

	function automatic void drop_level_bit(logic [LEVEL_W-1:0] lev);
		row_bits[lev[ROW_IDX_W +: ROW_IDX_W]][lev[ROW_IDX_W-1:0]] = 1'b0;
		if (row_bits[lev[ROW_IDX_W +: ROW_IDX_W]] == '0)
			group_bits[lev[ROW_IDX_W +: ROW_IDX_W]] = 1'b0;
	endfunction

	function automatic queue_result_t apply_queue_op(op_t op, logic [LEVEL_W-1:0] lev,
			logic [ITEM_W-1:0] data, logic [COUNT_W-1:0] cnt);
		queue_result_t r;
		int start;
		int stop;
		int ptr;
		logic [LEVEL_W-1:0] m;
		bit was_empty;
		r = '0;
		case (op)
			OP_LOAD: begin
				start = (lev == 0) ? 0 : int'(total_count);
				if (start + int'(cnt) > DEPTH) begin
					r.status = STAT_LOAD_OVF;
				end else begin
					// a level 0 load starts a new layout
					if (lev == 0) begin
						foreach (row_bits[i])
							row_bits[i] = '0;
						group_bits = '0;
					end
					region_base[lev] = COUNT_W'(start);
					fill_ptr[lev] = COUNT_W'(start);
					total_count = COUNT_W'(start + int'(cnt));
					drop_level_bit(lev);
					refresh_min();
				end
			end
			OP_PUSH: begin
				stop = (lev < NUM_LVL - 1) ? int'(region_base[lev + 1]) : int'(total_count);
				ptr = int'(fill_ptr[lev]);
				if (ptr >= stop || ptr >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					was_empty = (group_bits == '0);
					item_mem[ptr] = data;
					fill_ptr[lev] = COUNT_W'(ptr + 1);
					row_bits[lev[ROW_IDX_W +: ROW_IDX_W]][lev[ROW_IDX_W-1:0]] = 1'b1;
					group_bits[lev[ROW_IDX_W +: ROW_IDX_W]] = 1'b1;
					if (was_empty || lev < low_level) begin
						low_level = lev;
						r.new_minimum = 1'b1;
					end
				end
			end
			OP_POP: begin
				if (group_bits == '0) begin
					r.status = STAT_POP_EMPTY;
				end else begin
					m = low_level;
					ptr = int'(fill_ptr[m]);
					if (ptr > 0) begin
						ptr--;
						fill_ptr[m] = COUNT_W'(ptr);
						r.popped_item = item_mem[ptr];
					end
					if (ptr <= int'(region_base[m]))
						drop_level_bit(m);
					refresh_min();
				end
			end
			default: ;
		endcase
		r.queue_empty = (group_bits == '0);
		r.lowest_level = r.queue_empty ? '0 : low_level;
		return r;
	endfunction

	function automatic void check_field(string name, logic [ITEM_W-1:0] want,
			logic [ITEM_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// compare each result item, then predict for each accepted input item
	always @(posedge clk) begin : watch
		queue_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result item with nothing outstanding: tdata %h tuser %h",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("popped_item", want.popped_item, m_tdata[M_POP_LSB +: ITEM_W]);
					check_field("lowest_level", ITEM_W'(want.lowest_level),
						ITEM_W'(m_tdata[M_LOW_LSB +: LEVEL_W]));
					check_field("queue_empty", ITEM_W'(want.queue_empty),
						ITEM_W'(m_tdata[M_EMPTY_BIT]));
					check_field("new_minimum", ITEM_W'(want.new_minimum),
						ITEM_W'(m_tdata[M_NEWMIN_BIT]));
					check_field("status", ITEM_W'(want.status), ITEM_W'(m_tuser));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_queue_op(op_t'(s_tuser),
					s_tdata[S_LEVEL_LSB +: LEVEL_W], s_tdata[S_ITEM_LSB +: ITEM_W],
					s_tdata[S_COUNT_LSB +: COUNT_W]));
			results_owed = pending_results.size();
		end
	end

endmodule

// File: tb/bucket_queue_two_level_bitmap_top_test.sv
`timescale 1ns / 100ps

module bucket_queue_two_level_bitmap_top_test;
	import bqtlb_pkg::*;

	localparam int LAST_LEVEL   = NUM_LEVELS_DEF - 1;
	localparam int STORE_SIZE   = STORE_DEPTH_DEF;
	localparam int TOTAL_ITEMS  = 1825;
	localparam int HOLD_START   = 2500;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [OP_W-1:0]      s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	int                   fail_count;
	int                   results_owed;

	// levels ever laid out, and levels whose region bounds are all defined
	bit level_loaded [NUM_LEVELS_DEF];
	bit push_ok [NUM_LEVELS_DEF];
	int pushable[$];
	int alloc_total = 0;
	int items_sent = 0;
	int quiet_left = 0;

	bucket_queue_two_level_bitmap_top uut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	bucket_queue_monitor queue_watch (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.fail_count, .results_owed
	);

	always #5 clk = ~clk;

	function automatic void mark_pushable(int lev);
		if (!push_ok[lev] && level_loaded[lev] && (lev == LAST_LEVEL || level_loaded[lev + 1])) begin
			push_ok[lev] = 1'b1;
			pushable.push_back(lev);
		end
	endfunction

	function automatic int small_count();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 6);
	endfunction

	// offer one item, wait for accept, then maybe leave a gap
	task automatic send_item(op_t op, int lev, logic [ITEM_W-1:0] data, int cnt);
		logic [S_TDATA_W-1:0] word;
		int start;
		int g;
		word = '0;
		word[S_LEVEL_LSB +: LEVEL_W] = lev[LEVEL_W-1:0];
		word[S_ITEM_LSB +: ITEM_W] = data;
		word[S_COUNT_LSB +: COUNT_W] = cnt[COUNT_W-1:0];
		s_tdata <= word;
		s_tuser <= op;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		// track which loads take effect so pushes only touch laid-out levels
		if (op == OP_LOAD) begin
			start = (lev == 0) ? 0 : alloc_total;
			if (start + cnt <= STORE_SIZE) begin
				alloc_total = start + cnt;
				level_loaded[lev] = 1'b1;
				mark_pushable(lev);
				if (lev > 0)
					mark_pushable(lev - 1);
			end
		end
		if (quiet_left > 0) begin
			quiet_left--;
		end else if ($urandom_range(0, 99) < 3) begin
			quiet_left = $urandom_range(20, 80);
		end else begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic send_pop();
		send_item(OP_POP, $urandom_range(0, LAST_LEVEL), $urandom, $urandom_range(0, 131071));
	endtask

	// lay out a fresh set of levels, then push and pop within them
	task automatic run_frame();
		int frame_levels[$];
		int targets[$];
		int lev;
		int steps;
		int pick;
		send_item(OP_LOAD, 0, $urandom, small_count());
		frame_levels.push_back(0);
		lev = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, 600);
		steps = $urandom_range(1, 6);
		for (int i = 0; i < steps && lev < LAST_LEVEL; i++) begin
			send_item(OP_LOAD, lev, $urandom, small_count());
			send_item(OP_LOAD, lev + 1, $urandom, small_count());
			frame_levels.push_back(lev);
			frame_levels.push_back(lev + 1);
			lev += 2 + $urandom_range(0, 900);
		end
		if ($urandom_range(0, 3) == 0) begin
			send_item(OP_LOAD, LAST_LEVEL, $urandom, small_count());
			frame_levels.push_back(LAST_LEVEL);
		end
		foreach (frame_levels[i])
			if (push_ok[frame_levels[i]])
				targets.push_back(frame_levels[i]);
		repeat ($urandom_range(4, 40)) begin
			pick = $urandom_range(0, 99);
			if (pick < 55 && targets.size() > 0)
				send_item(OP_PUSH, targets[$urandom_range(0, targets.size() - 1)], $urandom,
					$urandom_range(0, 131071));
			else if (pick < 95)
				send_pop();
			else if (pick < 97)
				send_item(OP_NOP, $urandom_range(0, LAST_LEVEL), $urandom, $urandom_range(0, 131071));
			else
				send_item(OP_LOAD, frame_levels[$urandom_range(0, frame_levels.size() - 1)],
					$urandom, small_count());
		end
		// drain, often past empty
		repeat ($urandom_range(0, 12)) send_pop();
	endtask

	// unstructured items, including oversized loads
	task automatic run_noise();
		repeat ($urandom_range(3, 15)) begin
			case ($urandom_range(0, 3))
				0: send_item(OP_LOAD, $urandom_range(0, LAST_LEVEL), $urandom,
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 131071) : small_count());
				1: begin
					if (pushable.size() > 0)
						send_item(OP_PUSH, pushable[$urandom_range(0, pushable.size() - 1)],
							$urandom, $urandom_range(0, 131071));
					else
						send_pop();
				end
				2: send_pop();
				default: send_item(OP_NOP, $urandom_range(0, LAST_LEVEL), $urandom,
					$urandom_range(0, 131071));
			endcase
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_NOP;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on an empty queue, unused operation, load overflow at restart
		send_item(OP_POP, 0, '0, 0);
		send_item(OP_NOP, LAST_LEVEL, 32'hffffffff, 131071);
		send_item(OP_LOAD, 0, '0, 131071);
		send_item(OP_LOAD, 0, '0, STORE_SIZE + 1);
		// layout filling the store exactly, up to the last level
		send_item(OP_LOAD, 0, '0, 2);
		send_item(OP_LOAD, 1, '0, 1);
		send_item(OP_LOAD, 2, '0, 0);
		send_item(OP_LOAD, LAST_LEVEL - 1, '0, 1);
		send_item(OP_LOAD, LAST_LEVEL, '0, STORE_SIZE - 4);
		// pushes into an empty queue and below the minimum, then full buckets
		send_item(OP_PUSH, LAST_LEVEL, 32'hffffffff, 0);
		send_item(OP_PUSH, 1, 32'h00000000, 0);
		send_item(OP_PUSH, 0, 32'ha5a5a5a5, 0);
		send_item(OP_PUSH, 0, 32'h5a5a5a5a, 0);
		send_item(OP_PUSH, 0, 32'h12345678, 0);
		send_item(OP_PUSH, 1, 32'h87654321, 0);
		send_item(OP_PUSH, LAST_LEVEL - 1, 32'h0f0f0f0f, 0);
		// pops across levels, a reload that drops a level's items, pop past empty
		send_item(OP_POP, 0, '0, 0);
		send_item(OP_POP, 0, '0, 0);
		send_item(OP_LOAD, 1, '0, 0);
		send_item(OP_POP, 0, '0, 0);
		send_item(OP_POP, 0, '0, 0);
		send_item(OP_POP, 0, '0, 0);
		// whole store given to level 0
		send_item(OP_LOAD, 0, '0, STORE_SIZE);
		send_item(OP_PUSH, 0, 32'h80000001, 0);
		send_item(OP_POP, 0, '0, 0);

		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				run_noise();
			else
				run_frame();
		end
		s_tvalid <= 1'b0;

		do
			@(negedge clk);
		while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, calm stretches and one long hold-off
	initial begin : receiver
		int cyc;
		int stall_left;
		int mode_left;
		bit eager;
		cyc = 0;
		stall_left = 0;
		mode_left = 0;
		eager = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (cyc == HOLD_START) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				eager = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!eager && $urandom_range(0, 4) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
			cyc++;
		end
	end

	initial begin : watchdog
		#8000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
sv/bqtlb_pkg.sv
sv/bqtlb_ctrl.sv
sv/bqtlb_dp.sv
sv/bucket_queue_two_level_bitmap_top.sv
sv/bqtlb_checker.sv
tb/bucket_queue_monitor.sv
tb/bucket_queue_two_level_bitmap_top_test.sv
